// ===== rtl/conv3x3_scatter_accumulator_top_macros.svh =====
// Assertion helpers for the top-level RTL file of the convolution accumulator.
`ifndef CONV3X3_SCATTER_ACCUMULATOR_TOP_MACROS_SVH
`define CONV3X3_SCATTER_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C3SA_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("c3sa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define C3SA_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("c3sa assertion failed");

`endif

// ===== rtl/c3sa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package c3sa_pkg;

	// Store dimensions
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_IN_CH  = 64;
	localparam int MAX_OUT_CH = 4;
	localparam int KDIM       = 3;
	localparam int TAPS       = KDIM * KDIM;

	// Field widths
	localparam int ACTION_W   = 2;
	localparam int VALUE_W    = 8;
	localparam int POS_W      = 6;
	localparam int IC_W       = 6;
	localparam int OC_W       = 2;
	localparam int TAP_W      = 4;
	localparam int SUM_W      = 8;
	localparam int DIM_W      = 7;
	localparam int NOC_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int KIDX_W     = 2;

	// Memory geometry
	localparam int COL_A_W   = $clog2(MAX_WIDTH);
	localparam int ROW_A_W   = $clog2(MAX_HEIGHT);
	localparam int OCH_A_W   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int SUM_AW    = OCH_A_W + ROW_A_W + COL_A_W;
	localparam int SUM_DEPTH = 1 << SUM_AW;
	localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * TAPS;
	localparam int WGT_AW    = $clog2(WGT_DEPTH);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_NOC    = CFG_IDX_W'(2);

	typedef enum logic [ACTION_W-1:0] {
		ACT_WGT = 2'd0,
		ACT_PIX = 2'd1,
		ACT_RD  = 2'd2,
		ACT_CLR = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIXEL,
		ST_DRAIN,
		ST_RD_ISSUE,
		ST_RD_WAIT
	} state_t;

	// Clamped image geometry
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [NOC_W-1:0] nc;
	} geom_t;

	// One accumulate step handed to the MAC pipeline
	typedef struct packed {
		logic                      vld;
		logic [SUM_AW-1:0]         addr;
		logic signed [VALUE_W-1:0] pix;
	} mac_issue_t;

	typedef struct packed {
		logic              we;
		logic [SUM_AW-1:0] addr;
		logic [SUM_W-1:0]  data;
	} sum_wr_t;

	typedef struct packed {
		logic               we;
		logic [WGT_AW-1:0]  addr;
		logic [VALUE_W-1:0] data;
	} wgt_wr_t;

	// Weight location of (output channel, input channel, tap)
	function automatic logic [WGT_AW-1:0] wgt_addr(input int unsigned oc,
		input int unsigned ic, input int unsigned tp);
		return WGT_AW'((oc * MAX_IN_CH + ic) * TAPS + tp);
	endfunction

	// Sum location of (output channel, row, column)
	function automatic logic [SUM_AW-1:0] sum_addr(input int unsigned oc,
		input int unsigned r, input int unsigned c);
		return SUM_AW'((oc << (ROW_A_W + COL_A_W)) | (r << COL_A_W) | c);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/c3sa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c3sa_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, old data on collision
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/c3sa_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c3sa_mac (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire c3sa_pkg::mac_issue_t        issue,
	input  wire logic [c3sa_pkg::VALUE_W-1:0] wgt_rdata,
	input  wire logic [c3sa_pkg::SUM_W-1:0]   sum_rdata,
	output logic                             busy,
	output c3sa_pkg::sum_wr_t                wr
);

	import c3sa_pkg::*;

	logic                      vld_s1, vld_s2;
	logic [SUM_AW-1:0]         addr_s1, addr_s2;
	logic signed [VALUE_W-1:0] pix_s1;
	logic [SUM_W-1:0]          prod_s2, sum_s2;
	logic signed [2*VALUE_W-1:0] prod;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue.vld;
			vld_s2 <= vld_s1;
		end
	end

	// s1: memory reads in flight; s2: product and old sum
	assign prod = $signed(wgt_rdata) * pix_s1;

	always_ff @(posedge clk) begin
		addr_s1 <= issue.addr;
		pix_s1  <= issue.pix;
		addr_s2 <= addr_s1;
		prod_s2 <= prod[SUM_W-1:0];
		sum_s2  <= sum_rdata;
	end

	// Write back the wrapped sum
	always_comb begin
		wr.we   = vld_s2;
		wr.addr = addr_s2;
		wr.data = sum_s2 + prod_s2;
	end

	assign busy = vld_s1 | vld_s2;

endmodule

`default_nettype wire

// ===== rtl/c3sa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c3sa_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire c3sa_pkg::geom_t               geom,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [c3sa_pkg::ACTION_W-1:0] action,
	input  wire logic [c3sa_pkg::VALUE_W-1:0]  value,
	input  wire logic [c3sa_pkg::POS_W-1:0]    row,
	input  wire logic [c3sa_pkg::POS_W-1:0]    col,
	input  wire logic [c3sa_pkg::IC_W-1:0]     in_chan,
	input  wire logic [c3sa_pkg::OC_W-1:0]     out_chan,
	input  wire logic [c3sa_pkg::TAP_W-1:0]    tap,
	input  wire logic                          out_free,
	input  wire logic                          mac_busy,
	output c3sa_pkg::wgt_wr_t                  wgt_wr,
	output logic [c3sa_pkg::WGT_AW-1:0]        wgt_raddr,
	output logic [c3sa_pkg::SUM_AW-1:0]        sum_raddr,
	output c3sa_pkg::mac_issue_t               issue,
	output c3sa_pkg::sum_wr_t                  clr_wr,
	output logic                               rd_done,
	output logic                               rd_zero
);

	import c3sa_pkg::*;

	state_t                    state_q, state_d;
	logic signed [VALUE_W-1:0] val_q;
	logic [POS_W-1:0]          row_q, col_q;
	logic [IC_W-1:0]           ic_q;
	logic [OCH_A_W-1:0]        c_q;
	logic [KIDX_W-1:0]         ky_q, kx_q;
	logic [SUM_AW-1:0]         clr_cnt_q;
	logic [SUM_AW-1:0]         rd_addr_q;
	logic                      rd_ok_q;

	logic                      accept;
	logic                      pix_ok, rd_ok;
	logic signed [POS_W+1:0]   orow, ocol;
	logic                      orow_ok, ocol_ok, c_ok;
	logic                      step_last;
	logic [TAP_W-1:0]          tap_idx;

	assign accept = in_valid && !in_stall;

	// Range checks on the incoming item
	always_comb begin
		pix_ok = (32'(row) < 32'(geom.h)) && (32'(col) < 32'(geom.w)) &&
			(32'(in_chan) < MAX_IN_CH);
		rd_ok = (32'(row) < 32'(geom.h)) && (32'(col) < 32'(geom.w)) &&
			(32'(out_chan) < 32'(geom.nc));
	end

	// Neighbour position of the current step
	always_comb begin
		orow = $signed({2'b00, row_q}) + (POS_W+2)'(1) - $signed({{POS_W{1'b0}}, ky_q});
		ocol = $signed({2'b00, col_q}) + (POS_W+2)'(1) - $signed({{POS_W{1'b0}}, kx_q});
		orow_ok = !orow[POS_W+1] && (32'(orow[POS_W:0]) < 32'(geom.h));
		ocol_ok = !ocol[POS_W+1] && (32'(ocol[POS_W:0]) < 32'(geom.w));
		c_ok = 32'(c_q) < 32'(geom.nc);
		tap_idx = TAP_W'(ky_q) * TAP_W'(KDIM) + TAP_W'(kx_q);
		step_last = (ky_q == KIDX_W'(KDIM-1)) && (kx_q == KIDX_W'(KDIM-1)) &&
			((32'(c_q) + 1 >= 32'(geom.nc)) || (c_q == OCH_A_W'(MAX_OUT_CH-1)));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == SUM_AW'(SUM_DEPTH-1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (action_t'(action))
						ACT_WGT: state_d = ST_IDLE;
						ACT_PIX: state_d = pix_ok ? ST_PIXEL : ST_IDLE;
						ACT_RD:  state_d = ST_RD_ISSUE;
						ACT_CLR: state_d = ST_CLEAR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PIXEL: begin
				if (step_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_busy) state_d = ST_IDLE;
			end
			ST_RD_ISSUE: begin
				if (out_free) state_d = ST_RD_WAIT;
			end
			ST_RD_WAIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep counter and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			c_q       <= '0;
			ky_q      <= '0;
			kx_q      <= '0;
		end else if (state_q == ST_IDLE) begin
			clr_cnt_q <= '0;
			c_q       <= '0;
			ky_q      <= '0;
			kx_q      <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + SUM_AW'(1);
		end else if (state_q == ST_PIXEL) begin
			if (kx_q == KIDX_W'(KDIM-1)) begin
				kx_q <= '0;
				if (ky_q == KIDX_W'(KDIM-1)) begin
					ky_q <= '0;
					c_q  <= c_q + OCH_A_W'(1);
				end else begin
					ky_q <= ky_q + KIDX_W'(1);
				end
			end else begin
				kx_q <= kx_q + KIDX_W'(1);
			end
		end
	end

	// Item fields held for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= $signed(value);
			row_q     <= row;
			col_q     <= col;
			ic_q      <= in_chan;
			rd_ok_q   <= rd_ok;
			rd_addr_q <= sum_addr(32'(out_chan), 32'(row), 32'(col));
		end
	end

	// Outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);

		wgt_wr.we = accept && (action == ACT_WGT) && (32'(tap) < TAPS) &&
			(32'(in_chan) < MAX_IN_CH) && (32'(out_chan) < MAX_OUT_CH);
		wgt_wr.addr = wgt_addr(32'(out_chan), 32'(in_chan), 32'(tap));
		wgt_wr.data = value;

		wgt_raddr = wgt_addr(32'(c_q), 32'(ic_q), 32'(tap_idx));

		issue.vld  = (state_q == ST_PIXEL) && orow_ok && ocol_ok && c_ok;
		issue.addr = sum_addr(32'(c_q), 32'(orow[POS_W:0]), 32'(ocol[POS_W:0]));
		issue.pix  = val_q;

		sum_raddr = (state_q == ST_PIXEL) ? issue.addr : rd_addr_q;

		clr_wr.we   = (state_q == ST_CLEAR);
		clr_wr.addr = clr_cnt_q;
		clr_wr.data = '0;

		rd_done = (state_q == ST_RD_WAIT);
		rd_zero = !rd_ok_q;
	end

endmodule

`default_nettype wire

// ===== rtl/conv3x3_scatter_accumulator_top.sv =====
// 3x3 convolution accumulator (padding 1, stride 1) on signed 8-bit data in
// scatter form. Items write a weight, add a pixel into the partial sums of all
// active output channels, read one sum back, or clear all sums. Sums live in a
// 16384 x 8 synchronous memory and weights in a 2304 x 8 memory; a pixel add
// runs one read-modify-write of the sum memory per cycle through a
// multiply-accumulate pipeline (stages s1 and s2), walking output channel and
// tap over at least one and at most four output channels, then drains the
// pipeline, the drain being shorter when the last taps fall outside the image;
// a pixel outside the image and a weight write are taken without a stall, and
// a read stalls input until the result register is free and the sum is loaded.
// After reset and after every clear the sum memory is swept one entry a cycle
// with in_stall high; register writes are taken during the sweep. Weights read
// before being written return undefined data.
`timescale 1ns / 1ps
`default_nettype none
`include "conv3x3_scatter_accumulator_top_macros.svh"

module conv3x3_scatter_accumulator_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [c3sa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [c3sa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [c3sa_pkg::ACTION_W-1:0]   action,
	input  wire logic signed [c3sa_pkg::VALUE_W-1:0] value,
	input  wire logic [c3sa_pkg::POS_W-1:0]      row,
	input  wire logic [c3sa_pkg::POS_W-1:0]      col,
	input  wire logic [c3sa_pkg::IC_W-1:0]       in_chan,
	input  wire logic [c3sa_pkg::OC_W-1:0]       out_chan,
	input  wire logic [c3sa_pkg::TAP_W-1:0]      tap,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [c3sa_pkg::SUM_W-1:0]    sum_value
);

	import c3sa_pkg::*;

	logic [DIM_W-1:0]         width_q, height_q;
	logic [NOC_W-1:0]         noc_q;
	geom_t                    geom;

	wgt_wr_t                  wgt_wr;
	logic [WGT_AW-1:0]        wgt_raddr;
	logic [VALUE_W-1:0]       wgt_rdata;
	logic [SUM_AW-1:0]        sum_raddr;
	logic [SUM_W-1:0]         sum_rdata;
	mac_issue_t               issue;
	sum_wr_t                  clr_wr, mac_wr;
	logic                     sum_we;
	logic [SUM_AW-1:0]        sum_waddr;
	logic [SUM_W-1:0]         sum_wdata;
	logic                     mac_busy;
	logic                     rd_done, rd_zero;
	logic                     out_valid_q;
	logic signed [SUM_W-1:0]  sum_value_q;
	logic                     out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(64);
			height_q <= DIM_W'(64);
			noc_q    <= NOC_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_NOC:    noc_q    <= cfg_data[NOC_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate geometry at the store limits
	always_comb begin
		geom.w  = DIM_W'((32'(width_q) > MAX_WIDTH) ? MAX_WIDTH : 32'(width_q));
		geom.h  = DIM_W'((32'(height_q) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_q));
		geom.nc = NOC_W'((32'(noc_q) > MAX_OUT_CH) ? MAX_OUT_CH : 32'(noc_q));
	end

	c3sa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.value     (value),
		.row       (row),
		.col       (col),
		.in_chan   (in_chan),
		.out_chan  (out_chan),
		.tap       (tap),
		.out_free  (out_free),
		.mac_busy  (mac_busy),
		.wgt_wr    (wgt_wr),
		.wgt_raddr (wgt_raddr),
		.sum_raddr (sum_raddr),
		.issue     (issue),
		.clr_wr    (clr_wr),
		.rd_done   (rd_done),
		.rd_zero   (rd_zero)
	);

	c3sa_ram #(
		.DEPTH (WGT_DEPTH),
		.WIDTH (VALUE_W)
	) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_wr.we),
		.waddr (wgt_wr.addr),
		.wdata (wgt_wr.data),
		.raddr (wgt_raddr),
		.rdata (wgt_rdata)
	);

	// Sum memory write port: sweep or accumulate write-back
	always_comb begin
		sum_we    = clr_wr.we | mac_wr.we;
		sum_waddr = clr_wr.we ? clr_wr.addr : mac_wr.addr;
		sum_wdata = clr_wr.we ? clr_wr.data : mac_wr.data;
	end

	c3sa_ram #(
		.DEPTH (SUM_DEPTH),
		.WIDTH (SUM_W)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	c3sa_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.wgt_rdata (wgt_rdata),
		.sum_rdata (sum_rdata),
		.busy      (mac_busy),
		.wr        (mac_wr)
	);

	// Result register; frees on transfer
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_done) begin
			sum_value_q <= rd_zero ? '0 : $signed(sum_rdata);
		end
	end

	assign out_valid = out_valid_q;
	assign sum_value = sum_value_q;

	`C3SA_ASSERT_IMP(a_wr_excl, clk, arst_n, clr_wr.we, !mac_wr.we)
	`C3SA_ASSERT_IMP(a_out_free, clk, arst_n, rd_done, !out_valid_q)
	`C3SA_ASSERT_IMP(a_idle_drained, clk, arst_n, !in_stall, !mac_busy)
	`C3SA_ASSERT_NXT(a_rd_load, clk, arst_n, rd_done, out_valid_q)

endmodule

`default_nettype wire
